### sv/mwgp_pkg.sv
// Shared types, widths and codes for the max-weight monotone grid path block.
// Used by every module of the block but mwgp_ram, and by its checker; depends on nothing.
package mwgp_pkg;

  localparam int MAX_ROWS    = 32;
  localparam int MAX_COLS    = 32;
  localparam int WGT_W       = 16;
  localparam int SUM_W       = 22;
  localparam int DIM_W       = 6;
  localparam int CFG_IDX_W   = 1;
  localparam int STORE_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
  localparam int ROW_W       = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_W       = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int STACK_DEPTH = MAX_ROWS + MAX_COLS - 1;
  localparam int STACK_AW    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int MCNT_W      = $clog2(STACK_DEPTH + 1);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 1'b1;

  // Result kinds and move directions.
  localparam logic RES_SUM    = 1'b0;
  localparam logic RES_MOVE   = 1'b1;
  localparam logic MOVE_UP    = 1'b0;
  localparam logic MOVE_RIGHT = 1'b1;

  typedef logic signed [SUM_W-1:0] sum_t;

  typedef struct packed {
    logic has_below;
    logic has_left;
  } cell_nbr_t;

  // A size of zero acts as one; a size above the maximum acts as the maximum.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] res;
    res = v;
    if (v == '0) begin
      res = DIM_W'(1);
    end else if (v > maxv) begin
      res = maxv;
    end
    return res;
  endfunction

endpackage

### sv/mwgp_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// No dependencies; used for the grid store and the move stack.
module mwgp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/mwgp_cell_upd.sv
// Dynamic-programming update of one grid cell: adds the better neighbor sum.
// Depends on mwgp_pkg for the sum type and the neighbor flag struct.
module mwgp_cell_upd import mwgp_pkg::*; (
  input  sum_t      weight,
  input  sum_t      below_sum,
  input  sum_t      left_sum,
  input  cell_nbr_t nbr,
  output sum_t      new_sum,
  output logic      from_below
);

  sum_t pick;

  always_comb begin
    // On a tie the left neighbor wins, so the move into this cell is right.
    from_below = nbr.has_below && (!nbr.has_left || (below_sum > left_sum));
    if (from_below) begin
      pick = below_sum;
    end else if (nbr.has_left) begin
      pick = left_sum;
    end else begin
      pick = '0;
    end
    new_sum = weight + pick;
  end

endmodule

### sv/max_weight_monotone_grid_path.sv
// Top level of the max-weight monotone grid path block: control sequencer,
// grid store and move stack. Depends on mwgp_pkg, mwgp_ram and mwgp_cell_upd.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+----------------------------------
//   in      | input     | in_valid/in_stall  | in_cell_weight
//   out     | output    | out_valid/out_stall| out_result_kind, out_path_sum,
//           |           |                    | out_move_dir, out_last_result
//   cfg     | input     | cfg_we             | cfg_index, cfg_wdata
//
// Weights are taken one per cycle while loading. After the last weight the
// sweep visits all rows*cols cells through S_RD_OWN, S_RD_BELOW and S_CALC,
// bound by the single read port of the grid store, and the traceback steps
// through S_TB_RD and S_TB_CHK for each visited cell. The sum result and
// then each move are offered in S_OUT; S_POP reads each move off the stack.
// Reset is synchronous; the stores need no clearing pass. in_stall is high
// from the last weight until the final result has been taken.
module max_weight_monotone_grid_path import mwgp_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic signed [WGT_W-1:0] in_cell_weight,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   out_result_kind,
  output logic signed [SUM_W-1:0] out_path_sum,
  output logic                   out_move_dir,
  output logic                   out_last_result,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [DIM_W-1:0]       cfg_wdata
);

  localparam logic [2:0] S_LOAD     = 3'd0;
  localparam logic [2:0] S_RD_OWN   = 3'd1;
  localparam logic [2:0] S_RD_BELOW = 3'd2;
  localparam logic [2:0] S_CALC     = 3'd3;
  localparam logic [2:0] S_TB_RD    = 3'd4;
  localparam logic [2:0] S_TB_CHK   = 3'd5;
  localparam logic [2:0] S_OUT      = 3'd6;
  localparam logic [2:0] S_POP      = 3'd7;

  logic [2:0]        state_r, state_nxt;
  logic [DIM_W-1:0]  rows_cfg_r, cols_cfg_r;
  logic [CNT_W-1:0]  load_cnt_r, load_cnt_nxt;
  logic [ROW_W-1:0]  r_r, r_nxt;
  logic [COL_W-1:0]  c_r, c_nxt;
  logic [ADDR_W-1:0] base_r, base_nxt;
  sum_t              left_r, left_nxt;
  sum_t              wgt_r, wgt_nxt;
  sum_t              sum_cap_r, sum_cap_nxt;
  logic              first_r, first_nxt;
  logic [MCNT_W-1:0] mcnt_r, mcnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_kind_r, out_kind_nxt;
  sum_t              out_sum_r, out_sum_nxt;
  logic              out_dir_r, out_dir_nxt;
  logic              out_last_r, out_last_nxt;

  logic [DIM_W-1:0]   rows_c, cols_c;
  logic [ROW_W-1:0]   rows_m1;
  logic [COL_W-1:0]   cols_m1;
  logic [2*DIM_W-1:0] dim_prod;
  logic [CNT_W-1:0]   total;
  logic [CNT_W-1:0]   load_inc;
  logic [ADDR_W-1:0]  cols_a;
  logic [ADDR_W-1:0]  cell_addr, below_addr;
  logic [MCNT_W-1:0]  mcnt_dec;
  sum_t               wgt_ext;

  logic              g_we;
  logic [ADDR_W-1:0] g_waddr, g_raddr;
  logic [SUM_W:0]    g_wdata, g_rdata;
  sum_t              g_rsum;
  logic              g_rfb;

  logic                s_we;
  logic [STACK_AW-1:0] s_waddr, s_raddr;
  logic                s_wdata, s_rdata;

  cell_nbr_t nbr;
  sum_t      upd_sum;
  logic      upd_fb;

  assign rows_c     = clamp_dim(rows_cfg_r, DIM_W'(MAX_ROWS));
  assign cols_c     = clamp_dim(cols_cfg_r, DIM_W'(MAX_COLS));
  assign rows_m1    = ROW_W'(rows_c - DIM_W'(1));
  assign cols_m1    = COL_W'(cols_c - DIM_W'(1));
  assign dim_prod   = {{DIM_W{1'b0}}, rows_c} * {{DIM_W{1'b0}}, cols_c};
  assign total      = CNT_W'(dim_prod);
  assign load_inc   = load_cnt_r + CNT_W'(1);
  assign cols_a     = ADDR_W'(cols_c);
  assign cell_addr  = base_r + ADDR_W'(c_r);
  assign below_addr = cell_addr + cols_a;
  assign mcnt_dec   = mcnt_r - MCNT_W'(1);
  assign wgt_ext    = {{(SUM_W-WGT_W){in_cell_weight[WGT_W-1]}}, in_cell_weight};
  assign g_rsum     = g_rdata[SUM_W-1:0];
  assign g_rfb      = g_rdata[SUM_W];

  assign nbr.has_below = (r_r != rows_m1);
  assign nbr.has_left  = (c_r != '0);

  assign in_stall        = (state_r != S_LOAD);
  assign out_valid       = out_valid_r;
  assign out_result_kind = out_kind_r;
  assign out_path_sum    = out_sum_r;
  assign out_move_dir    = out_dir_r;
  assign out_last_result = out_last_r;

  // Grid store: bit SUM_W is the reached-from-below flag, the rest the sum.
  mwgp_ram #(.WIDTH(SUM_W + 1), .DEPTH(STORE_DEPTH)) u_grid_ram (
    .clk   (clk),
    .we    (g_we),
    .waddr (g_waddr),
    .wdata (g_wdata),
    .raddr (g_raddr),
    .rdata (g_rdata)
  );

  mwgp_ram #(.WIDTH(1), .DEPTH(STACK_DEPTH)) u_stack_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  mwgp_cell_upd u_cell_upd (
    .weight     (wgt_r),
    .below_sum  (g_rsum),
    .left_sum   (left_r),
    .nbr        (nbr),
    .new_sum    (upd_sum),
    .from_below (upd_fb)
  );

  always_comb begin
    state_nxt     = state_r;
    load_cnt_nxt  = load_cnt_r;
    r_nxt         = r_r;
    c_nxt         = c_r;
    base_nxt      = base_r;
    left_nxt      = left_r;
    wgt_nxt       = wgt_r;
    sum_cap_nxt   = sum_cap_r;
    first_nxt     = first_r;
    mcnt_nxt      = mcnt_r;
    out_valid_nxt = out_valid_r;
    out_kind_nxt  = out_kind_r;
    out_sum_nxt   = out_sum_r;
    out_dir_nxt   = out_dir_r;
    out_last_nxt  = out_last_r;
    g_we          = 1'b0;
    g_waddr       = cell_addr;
    g_wdata       = '0;
    g_raddr       = cell_addr;
    s_we          = 1'b0;
    s_waddr       = mcnt_r[STACK_AW-1:0];
    s_wdata       = MOVE_UP;
    s_raddr       = mcnt_dec[STACK_AW-1:0];

    unique case (state_r)
      S_LOAD: begin
        if (in_valid) begin
          g_we    = 1'b1;
          g_waddr = load_cnt_r[ADDR_W-1:0];
          g_wdata = {1'b0, wgt_ext};
          // A size shrunk partway through a load starts the run at the next weight.
          if (load_inc >= total) begin
            load_cnt_nxt = '0;
            r_nxt        = rows_m1;
            c_nxt        = '0;
            base_nxt     = ADDR_W'(total - CNT_W'(cols_c));
            state_nxt    = S_RD_OWN;
          end else begin
            load_cnt_nxt = load_inc;
          end
        end
      end
      S_RD_OWN: begin
        g_raddr   = cell_addr;
        state_nxt = S_RD_BELOW;
      end
      S_RD_BELOW: begin
        g_raddr   = below_addr;
        wgt_nxt   = g_rsum;
        state_nxt = S_CALC;
      end
      S_CALC: begin
        g_we     = 1'b1;
        g_waddr  = cell_addr;
        g_wdata  = {upd_fb, upd_sum};
        left_nxt = upd_sum;
        if (c_r == cols_m1) begin
          if (r_r == '0) begin
            // Sweep done; trace back from the top-right cell.
            r_nxt     = '0;
            c_nxt     = cols_m1;
            base_nxt  = '0;
            mcnt_nxt  = '0;
            first_nxt = 1'b1;
            state_nxt = S_TB_RD;
          end else begin
            r_nxt     = r_r - ROW_W'(1);
            c_nxt     = '0;
            base_nxt  = base_r - cols_a;
            state_nxt = S_RD_OWN;
          end
        end else begin
          c_nxt     = c_r + COL_W'(1);
          state_nxt = S_RD_OWN;
        end
      end
      S_TB_RD: begin
        g_raddr   = cell_addr;
        state_nxt = S_TB_CHK;
      end
      S_TB_CHK: begin
        first_nxt = 1'b0;
        if (first_r) begin
          sum_cap_nxt = g_rsum;
        end
        if ((r_r == rows_m1) && (c_r == '0)) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = RES_SUM;
          out_sum_nxt   = first_r ? g_rsum : sum_cap_r;
          out_dir_nxt   = MOVE_UP;
          out_last_nxt  = (mcnt_r == '0);
          state_nxt     = S_OUT;
        end else begin
          s_we     = 1'b1;
          s_waddr  = mcnt_r[STACK_AW-1:0];
          mcnt_nxt = mcnt_r + MCNT_W'(1);
          if (g_rfb) begin
            s_wdata  = MOVE_UP;
            r_nxt    = r_r + ROW_W'(1);
            base_nxt = base_r + cols_a;
          end else begin
            s_wdata = MOVE_RIGHT;
            c_nxt   = c_r - COL_W'(1);
          end
          state_nxt = S_TB_RD;
        end
      end
      S_OUT: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            state_nxt = S_LOAD;
          end else begin
            // Moves come off the stack in reverse, so they leave start first.
            mcnt_nxt  = mcnt_dec;
            s_raddr   = mcnt_dec[STACK_AW-1:0];
            state_nxt = S_POP;
          end
        end
      end
      S_POP: begin
        out_valid_nxt = 1'b1;
        out_kind_nxt  = RES_MOVE;
        out_sum_nxt   = '0;
        out_dir_nxt   = s_rdata;
        out_last_nxt  = (mcnt_r == '0);
        state_nxt     = S_OUT;
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      rows_cfg_r  <= DIM_W'(MAX_ROWS);
      cols_cfg_r  <= DIM_W'(MAX_COLS);
      load_cnt_r  <= '0;
      mcnt_r      <= '0;
      first_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      load_cnt_r  <= load_cnt_nxt;
      mcnt_r      <= mcnt_nxt;
      first_r     <= first_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_GRID_ROWS: rows_cfg_r <= cfg_wdata;
          CFG_GRID_COLS: cols_cfg_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    r_r        <= r_nxt;
    c_r        <= c_nxt;
    base_r     <= base_nxt;
    left_r     <= left_nxt;
    wgt_r      <= wgt_nxt;
    sum_cap_r  <= sum_cap_nxt;
    out_kind_r <= out_kind_nxt;
    out_sum_r  <= out_sum_nxt;
    out_dir_r  <= out_dir_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

### sv/mwgp_checker.sv
// Port-level checker for max_weight_monotone_grid_path, bound to the top level.
// Depends on mwgp_pkg for widths and result codes.
module mwgp_checker import mwgp_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic                    out_result_kind,
  input logic signed [SUM_W-1:0] out_path_sum,
  input logic                    out_move_dir,
  input logic                    out_last_result
);

  // New requests are only taken while no result is on offer.
  a_no_load_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_valid && !in_stall))
    else $error("input taken while a result is pending");

  // An accepted weight never produces a result in the very next cycle.
  a_no_out_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> !out_valid)
    else $error("result offered right after an input request");

  // After the final result of a run is taken, the output goes quiet.
  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_last_result) |=> !out_valid)
    else $error("result offered after the final result");

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_result_kind) &&
      $stable(out_path_sum) && $stable(out_move_dir) && $stable(out_last_result)))
    else $error("stalled result changed");

  // Unused fields of each result kind stay at zero.
  a_kind_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_result_kind == RES_SUM && out_move_dir == MOVE_UP) ||
      (out_result_kind == RES_MOVE && out_path_sum == '0)))
    else $error("result carries a stray field value");

endmodule

bind max_weight_monotone_grid_path mwgp_checker u_mwgp_checker (.*);

### dv/grid_path_monitor.sv
`timescale 1ns / 1ps
// Result monitor for the max-weight monotone grid path block. It follows the size registers and
// the weight requests, predicts the best sum and the move list, and compares every result.
// Depends on mwgp_pkg for widths, register indexes, result kinds and move codes.
module grid_path_monitor import mwgp_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic signed [WGT_W-1:0] in_cell_weight,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic                    out_result_kind,
  input  logic signed [SUM_W-1:0] out_path_sum,
  input  logic                    out_move_dir,
  input  logic                    out_last_result,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [DIM_W-1:0]        cfg_wdata,
  output int                      errors,
  output int                      pending,
  output int                      results_checked,
  output int                      grids_solved
);

  localparam int PRINT_CAP = 50;

  typedef struct packed {
    logic kind;
    sum_t path_sum;
    logic dir;
    logic is_last;
  } path_result_t;

  logic [DIM_W-1:0] rows_reg;
  logic [DIM_W-1:0] cols_reg;
  logic [CNT_W-1:0] load_pos;
  int               grid_weight [STORE_DEPTH];
  int               best_sum [STORE_DEPTH];
  logic             from_below [STORE_DEPTH];
  path_result_t     path_results_due [$];

  function automatic int eff_dim(input logic [DIM_W-1:0] v, input int max_v);
    if (v == '0) return 1;
    if (int'(v) > max_v) return max_v;
    return int'(v);
  endfunction

  task automatic report_mismatch(input string msg);
    if (errors < PRINT_CAP) $display("[%0t] mismatch: %s", $time, msg);
    errors++;
  endtask

  // Sweep from the bottom row up, then walk back from the top-right corner. Moves are found
  // from the end of the path, so each one goes to the front of the list.
  task automatic solve_grid(input int rows, input int cols);
    int           r;
    int           c;
    int           idx;
    int           r_at;
    int           c_at;
    logic         dirs [$];
    path_result_t res;
    for (r = rows - 1; r >= 0; r--) begin
      for (c = 0; c < cols; c++) begin
        idx = r * cols + c;
        best_sum[idx] = grid_weight[idx];
        if (!(r == rows - 1 && c == 0)) begin
          if (c == 0) begin
            best_sum[idx] += best_sum[idx + cols];
            from_below[idx] = 1'b1;
          end else if (r == rows - 1) begin
            best_sum[idx] += best_sum[idx - 1];
            from_below[idx] = 1'b0;
          end else if (best_sum[idx + cols] > best_sum[idx - 1]) begin
            best_sum[idx] += best_sum[idx + cols];
            from_below[idx] = 1'b1;
          end else begin
            // A tie goes to the left neighbor.
            best_sum[idx] += best_sum[idx - 1];
            from_below[idx] = 1'b0;
          end
        end
      end
    end
    r_at = 0;
    c_at = cols - 1;
    while (!(r_at == rows - 1 && c_at == 0)) begin
      if (from_below[r_at * cols + c_at]) begin
        dirs.push_front(MOVE_UP);
        r_at++;
      end else begin
        dirs.push_front(MOVE_RIGHT);
        c_at--;
      end
    end
    res.kind     = RES_SUM;
    res.path_sum = sum_t'(best_sum[cols - 1]);
    res.dir      = MOVE_UP;
    res.is_last  = (dirs.size() == 0);
    path_results_due.push_back(res);
    foreach (dirs[i]) begin
      res.kind     = RES_MOVE;
      res.path_sum = '0;
      res.dir      = dirs[i];
      res.is_last  = (i == dirs.size() - 1);
      path_results_due.push_back(res);
    end
    grids_solved++;
  endtask

  task automatic take_weight(input logic signed [WGT_W-1:0] w);
    int rows;
    int cols;
    rows = eff_dim(rows_reg, MAX_ROWS);
    cols = eff_dim(cols_reg, MAX_COLS);
    grid_weight[load_pos[ADDR_W-1:0]] = int'(w);
    load_pos = load_pos + 1'b1;
    if (int'(load_pos) >= rows * cols) begin
      solve_grid(rows, cols);
      load_pos = '0;
    end
  endtask

  task automatic check_result();
    path_result_t want;
    if (path_results_due.size() == 0) begin
      report_mismatch($sformatf("result with nothing expected (kind %0b sum %0d dir %0b last %0b)",
                                out_result_kind, out_path_sum, out_move_dir, out_last_result));
      return;
    end
    want = path_results_due.pop_front();
    results_checked++;
    if (out_result_kind !== want.kind)
      report_mismatch($sformatf("result_kind got %0b want %0b", out_result_kind, want.kind));
    if (out_path_sum !== want.path_sum)
      report_mismatch($sformatf("path_sum got %0d want %0d", out_path_sum, want.path_sum));
    if (out_move_dir !== want.dir)
      report_mismatch($sformatf("move_dir got %0b want %0b", out_move_dir, want.dir));
    if (out_last_result !== want.is_last)
      report_mismatch($sformatf("last_result got %0b want %0b", out_last_result, want.is_last));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      rows_reg = DIM_W'(MAX_ROWS);
      cols_reg = DIM_W'(MAX_COLS);
      load_pos = '0;
      path_results_due.delete();
      errors = 0;
      results_checked = 0;
      grids_solved = 0;
    end else begin
      // A weight taken at the same edge as a size write still sees the old size.
      if (in_valid && !in_stall) take_weight(in_cell_weight);
      if (cfg_we) begin
        if (cfg_index == CFG_GRID_ROWS) begin
          rows_reg = cfg_wdata;
        end else if (cfg_index == CFG_GRID_COLS) begin
          cols_reg = cfg_wdata;
        end
      end
      if (out_valid && !out_stall) check_result();
    end
    pending = path_results_due.size();
  end

endmodule

### dv/max_weight_monotone_grid_path_tb.sv
`timescale 1ns / 1ps
// Testbench top for the max-weight monotone grid path block: clock, reset, weight and size
// stimulus, output stalls and the verdict. Depends on mwgp_pkg and grid_path_monitor.
module max_weight_monotone_grid_path_tb;
  import mwgp_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int LONG_HOLD    = 400;
  localparam int SETTLE       = 8;
  localparam int RANDOM_ITEMS = 155;

  logic                    clk;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic signed [WGT_W-1:0] in_cell_weight = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic                    out_result_kind;
  logic signed [SUM_W-1:0] out_path_sum;
  logic                    out_move_dir;
  logic                    out_last_result;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = CFG_GRID_ROWS;
  logic [DIM_W-1:0]        cfg_wdata = '0;

  int errors;
  int pending;
  int results_checked;
  int grids_solved;
  int cycles = 0;
  int weights_sent = 0;
  bit quiet = 1'b0;
  bit long_hold_req = 1'b0;

  max_weight_monotone_grid_path DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_cell_weight(in_cell_weight),
    .out_valid(out_valid), .out_stall(out_stall), .out_result_kind(out_result_kind),
    .out_path_sum(out_path_sum), .out_move_dir(out_move_dir), .out_last_result(out_last_result),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  grid_path_monitor path_mon (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_cell_weight(in_cell_weight),
    .out_valid(out_valid), .out_stall(out_stall), .out_result_kind(out_result_kind),
    .out_path_sum(out_path_sum), .out_move_dir(out_move_dir), .out_last_result(out_last_result),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .errors(errors), .pending(pending), .results_checked(results_checked),
    .grids_solved(grids_solved)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycles, pending);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Output side: random stall bursts, calm stretches, and one long hold on request.
  initial begin : result_sink
    int span;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall <= 1'b1;
        for (span = 0; span < LONG_HOLD; span++) @(posedge clk);
        out_stall <= 1'b0;
        @(posedge clk);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  // Leaves in_valid high after the request is taken, so back-to-back weights need no gap.
  task automatic send_weight(input logic signed [WGT_W-1:0] w);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cell_weight <= w;
    do @(posedge clk); while (in_stall);
    weights_sent++;
  endtask

  task automatic stop_sending();
    in_valid <= 1'b0;
  endtask

  // Size writes wait until every result has drained and the block has settled.
  task automatic set_size(input logic [DIM_W-1:0] r, input logic [DIM_W-1:0] c);
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_GRID_ROWS;
    cfg_wdata <= r;
    @(posedge clk);
    cfg_index <= CFG_GRID_COLS;
    cfg_wdata <= c;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [WGT_W-1:0] pick_weight(input int mode);
    logic signed [WGT_W-1:0] w;
    int                      pick;
    case (mode)
      1: w = WGT_W'(int'($urandom_range(0, 4)) - 2);
      2: begin
        pick = $urandom_range(0, 4);
        if (pick == 0) w = {1'b1, {(WGT_W-1){1'b0}}};
        else if (pick == 1) w = {1'b0, {(WGT_W-1){1'b1}}};
        else w = WGT_W'($urandom);
      end
      default: w = WGT_W'($urandom);
    endcase
    return w;
  endfunction

  // Picks an in-use size and the raw register values for it, sometimes zero or oversize.
  task automatic pick_size(input bit small_only, output int er, output int ec,
                           output logic [DIM_W-1:0] rr, output logic [DIM_W-1:0] rc);
    int               sel;
    int               a;
    int               b;
    logic [DIM_W-1:0] ra;
    logic [DIM_W-1:0] rb;
    sel = small_only ? 9 : $urandom_range(0, 9);
    if (sel == 0) begin
      a = MAX_ROWS;
      ra = $urandom_range(0, 1) ? DIM_W'(MAX_ROWS) : DIM_W'($urandom_range(33, 63));
    end else if (sel == 1) begin
      a = $urandom_range(7, 31);
      ra = DIM_W'(a);
    end else if (sel == 2) begin
      a = 1;
      ra = $urandom_range(0, 1) ? DIM_W'(0) : DIM_W'(1);
    end else begin
      a = $urandom_range(2, 6);
      ra = DIM_W'(a);
    end
    b = (a > 6) ? $urandom_range(1, 2) : $urandom_range(1, 6);
    rb = (b == 1 && $urandom_range(0, 1)) ? DIM_W'(0) : DIM_W'(b);
    if ($urandom_range(0, 1)) begin
      er = a; rr = ra; ec = b; rc = rb;
    end else begin
      er = b; rr = rb; ec = a; rc = ra;
    end
  endtask

  initial begin : stimulus
    int               k;
    int               n;
    int               loaded;
    int               cur_cells;
    int               resize_at;
    int               mode;
    int               er;
    int               ec;
    int               random_items;
    logic [DIM_W-1:0] rr;
    logic [DIM_W-1:0] rc;
    bit               keep_size;
    bit               hold_this;
    bit               hold_done;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Three weights at the reset size, then a shrink to one cell: the next weight starts the
    // run on the first cell loaded.
    send_weight(16'sh7fff);
    send_weight(16'sh8000);
    send_weight(16'sh5555);
    stop_sending();
    set_size('0, '0);
    send_weight(16'sh8000);
    send_weight(16'sh7fff);
    send_weight(16'sh8000);
    stop_sending();

    // Two by two, first with every weight equal, then with mirrored extremes; each choice is a tie.
    set_size(DIM_W'(2), DIM_W'(2));
    repeat (4) send_weight(16'sd7);
    send_weight(16'sh8000);
    send_weight(16'sh7fff);
    send_weight(16'sh7fff);
    send_weight(16'sh8000);
    stop_sending();

    // Single row gives only right moves, single column only up moves.
    set_size(DIM_W'(1), DIM_W'(3));
    send_weight(16'sd1);
    send_weight(-16'sd2);
    send_weight(16'sd3);
    stop_sending();
    set_size(DIM_W'(3), DIM_W'(1));
    repeat (3) send_weight(-16'sd1);
    stop_sending();

    // Grow the grid partway through a load.
    set_size(DIM_W'(1), DIM_W'(2));
    send_weight(16'sd100);
    stop_sending();
    set_size(DIM_W'(2), DIM_W'(2));
    send_weight(-16'sd50);
    send_weight(16'sd20);
    send_weight(16'sh1234);
    stop_sending();

    // A full-height column once, with the row register above its maximum and columns at zero.
    set_size(DIM_W'(63), DIM_W'(0));
    for (k = 0; k < MAX_ROWS; k++) send_weight(pick_weight(0));
    stop_sending();

    random_items = 0;
    keep_size = 1'b0;
    hold_done = 1'b0;
    cur_cells = 1;
    while (random_items < RANDOM_ITEMS) begin
      if (!keep_size) begin
        pick_size(1'b0, er, ec, rr, rc);
        set_size(rr, rc);
        cur_cells = er * ec;
      end
      keep_size = 1'b0;
      loaded = 0;
      n = cur_cells;
      // Once, hold the output side long while the next grid is already being offered.
      hold_this = !hold_done && random_items >= 40 && n >= 2 && n <= 40;
      resize_at = (!hold_this && n > 1 && $urandom_range(0, 5) == 0) ?
                  $urandom_range(1, n - 1) : 0;
      mode = $urandom_range(0, 2);
      while (loaded < n) begin
        if (resize_at != 0 && loaded == resize_at) begin
          stop_sending();
          pick_size(1'b1, er, ec, rr, rc);
          set_size(rr, rc);
          cur_cells = er * ec;
          n = (cur_cells > loaded) ? cur_cells : loaded + 1;
          resize_at = 0;
        end
        if (hold_this && loaded == n - 1) long_hold_req = 1'b1;
        send_weight(pick_weight(mode));
        loaded++;
        random_items++;
        quiet = (random_items >= RANDOM_ITEMS - 30);
      end
      if (hold_this) begin
        keep_size = 1'b1;
        hold_done = 1'b1;
      end else begin
        stop_sending();
      end
    end
    stop_sending();

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Sent %0d weights over %0d grids, from one cell up to 32 rows or columns,",
             weights_sent, grids_solved);
    $display("with resizes in a load, stall bursts and a long output hold; %0d results checked.",
             results_checked);
    if (errors == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d results never seen", errors, pending);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### filelist.f
sv/mwgp_pkg.sv
sv/mwgp_ram.sv
sv/mwgp_cell_upd.sv
sv/max_weight_monotone_grid_path.sv
sv/mwgp_checker.sv
dv/grid_path_monitor.sv
dv/max_weight_monotone_grid_path_tb.sv
